FILE: src/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

   // field widths
   localparam int HUE_W  = 9;
   localparam int CHAN_W = 8;
   localparam int FRAC_W = 6;

   // sector geometry
   localparam int SECTOR_DEG = 60;
   localparam int CHAN_MAX   = 255;
   localparam int FRAC_DEN   = SECTOR_DEG * CHAN_MAX;
   localparam int SECTOR_CNT = 6;
   // highest whole sector index a 9-bit hue can reach
   localparam int QUOT_MAX   = ((1 << HUE_W) - 1) / SECTOR_DEG;
   localparam int QUOT_W     = $clog2(QUOT_MAX + 1);

   // intermediate widths
   localparam int NUM_W   = $clog2(FRAC_DEN + 1);            // 15300 - s*f
   localparam int PNUM_W  = 2 * CHAN_W;                      // v*(255-s)
   localparam int QPROD_W = $clog2(CHAN_MAX * FRAC_DEN + 1); // v*(15300-s*f)

   // reciprocal multipliers, estimate is low by at most one
   localparam int P_RECIP = 257;
   localparam int P_SHIFT = 16;
   localparam int PREC_W  = PNUM_W + 9;
   localparam int Q_RECIP = (1 << 30) / FRAC_DEN;
   localparam int Q_SHIFT = 30;
   localparam int QREC_W  = QPROD_W + 17;

   // occupancy bound of the pipeline
   localparam int PIPE_DEPTH = 5;

   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW  = 3'd0,
      SECTOR_YELLOW_GRN  = 3'd1,
      SECTOR_GREEN_CYAN  = 3'd2,
      SECTOR_CYAN_BLUE   = 3'd3,
      SECTOR_BLUE_MAG    = 3'd4,
      SECTOR_MAG_RED     = 3'd5
   } sector_type;

endpackage

FILE: src/hsv_to_rgb_converter_top.sv
// hsv to rgb converter, 8-bit channels, six-sector model
//
// request channel: req_valid / req_ready carry one pixel as hue in whole
// degrees (9 bits, 360 and above wrap to the start of the circle),
// saturation and brightness (8 bits each)
// result channel: rsp_valid / rsp_ready carry red, green and blue, one
// result per request, in request order
//
// path: each request is registered in stages 1 through 5 in order before rsp_valid
// throughput: one request per cycle, limited only by the receiver
// stages: hue sector split, first products, value products,
// reciprocal multiplies, quotient correction plus channel select
//
// reset: synchronous, active high; clears every stage valid bit, so the
// pipeline comes up empty and ready
// receiver stall: each stage holds while the one ahead is full, bubbles
// still close up, so requests keep entering until all five stages hold data
module hsv_to_rgb_converter_top
   import hsv2rgb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [HUE_W-1:0]  req_hue_deg,
   input  logic [CHAN_W-1:0] req_saturation,
   input  logic [CHAN_W-1:0] req_brightness,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHAN_W-1:0] rsp_red,
   output logic [CHAN_W-1:0] rsp_green,
   output logic [CHAN_W-1:0] rsp_blue
);

   // per-stage ready, a stage moves when it is empty or the next one moves
   logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;

   // stage 1: sector and position inside the sector
   logic                s1_valid_ff;
   sector_type          s1_sector_ff, s1_sector_in;
   logic [FRAC_W-1:0]   s1_frac_ff, s1_frac_in;
   logic [CHAN_W-1:0]   s1_sat_ff, s1_val_ff;
   logic [QUOT_W-1:0]   s1_quot;
   logic [HUE_W-1:0]    s1_base;
   logic [HUE_W-1:0]    s1_rem;

   // stage 2: numerators
   logic                s2_valid_ff;
   sector_type          s2_sector_ff;
   logic [CHAN_W-1:0]   s2_val_ff;
   logic [PNUM_W-1:0]   s2_pnum_ff, s2_pnum_in;
   logic [NUM_W-1:0]    s2_qnum_ff, s2_qnum_in;
   logic [NUM_W-1:0]    s2_tnum_ff, s2_tnum_in;
   logic [FRAC_W-1:0]   s1_frac_cmp;

   // stage 3: value times numerator
   logic                s3_valid_ff;
   sector_type          s3_sector_ff;
   logic [CHAN_W-1:0]   s3_val_ff;
   logic [PNUM_W-1:0]   s3_pnum_ff;
   logic [QPROD_W-1:0]  s3_qprod_ff, s3_qprod_in;
   logic [QPROD_W-1:0]  s3_tprod_ff, s3_tprod_in;

   // stage 4: reciprocal products
   logic                s4_valid_ff;
   sector_type          s4_sector_ff;
   logic [CHAN_W-1:0]   s4_val_ff;
   logic [PNUM_W-1:0]   s4_pnum_ff;
   logic [QPROD_W-1:0]  s4_qprod_ff, s4_tprod_ff;
   logic [PREC_W-1:0]   s4_prec_ff, s4_prec_in;
   logic [QREC_W-1:0]   s4_qrec_ff, s4_qrec_in;
   logic [QREC_W-1:0]   s4_trec_ff, s4_trec_in;

   // stage 5: corrected quotients and channel select
   logic                rsp_valid_ff;
   logic [CHAN_W-1:0]   rsp_red_ff, rsp_red_in;
   logic [CHAN_W-1:0]   rsp_green_ff, rsp_green_in;
   logic [CHAN_W-1:0]   rsp_blue_ff, rsp_blue_in;
   logic [CHAN_W-1:0]   p_est, q_est, t_est;
   logic [PNUM_W:0]     p_rem;
   logic [QPROD_W-1:0]  q_rem, t_rem;
   logic [CHAN_W-1:0]   p_chan, q_chan, t_chan;

   assign s5_ready  = !rsp_valid_ff || rsp_ready;
   assign s4_ready  = !s4_valid_ff || s5_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   // ---------------------------------------------------------------
   // stage 1: hue / 60 by threshold compares, then wrap into six sectors
   always_comb begin
      s1_quot = '0;
      for (int k = 1; k <= QUOT_MAX; k++) begin
         if (req_hue_deg >= HUE_W'(k * SECTOR_DEG)) begin
            s1_quot = QUOT_W'(k);
         end
      end
      s1_base = HUE_W'(s1_quot * SECTOR_DEG);
      s1_rem  = req_hue_deg - s1_base;
      s1_frac_in = s1_rem[FRAC_W-1:0];
      if (s1_quot >= QUOT_W'(SECTOR_CNT)) begin
         s1_sector_in = sector_type'(3'(s1_quot - QUOT_W'(SECTOR_CNT)));
      end else begin
         s1_sector_in = sector_type'(3'(s1_quot));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (s1_ready && req_valid) begin
         s1_sector_ff <= s1_sector_in;
         s1_frac_ff   <= s1_frac_in;
         s1_sat_ff    <= req_saturation;
         s1_val_ff    <= req_brightness;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: v*(255-s), 15300 - s*f, 15300 - s*(60-f)
   assign s1_frac_cmp = FRAC_W'(SECTOR_DEG) - s1_frac_ff;
   assign s2_pnum_in  = PNUM_W'(s1_val_ff) * PNUM_W'(CHAN_W'(CHAN_MAX) - s1_sat_ff);
   assign s2_qnum_in  = NUM_W'(FRAC_DEN) - NUM_W'(s1_sat_ff) * NUM_W'(s1_frac_ff);
   assign s2_tnum_in  = NUM_W'(FRAC_DEN) - NUM_W'(s1_sat_ff) * NUM_W'(s1_frac_cmp);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_sector_ff <= s1_sector_ff;
         s2_val_ff    <= s1_val_ff;
         s2_pnum_ff   <= s2_pnum_in;
         s2_qnum_ff   <= s2_qnum_in;
         s2_tnum_ff   <= s2_tnum_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 3: scale the q and t numerators by v
   assign s3_qprod_in = QPROD_W'(s2_val_ff) * QPROD_W'(s2_qnum_ff);
   assign s3_tprod_in = QPROD_W'(s2_val_ff) * QPROD_W'(s2_tnum_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_sector_ff <= s2_sector_ff;
         s3_val_ff    <= s2_val_ff;
         s3_pnum_ff   <= s2_pnum_ff;
         s3_qprod_ff  <= s3_qprod_in;
         s3_tprod_ff  <= s3_tprod_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 4: multiply by the truncated reciprocals of 255 and 15300
   assign s4_prec_in = PREC_W'(s3_pnum_ff) * PREC_W'(P_RECIP);
   assign s4_qrec_in = QREC_W'(s3_qprod_ff) * QREC_W'(Q_RECIP);
   assign s4_trec_in = QREC_W'(s3_tprod_ff) * QREC_W'(Q_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_ready) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (s4_ready && s3_valid_ff) begin
         s4_sector_ff <= s3_sector_ff;
         s4_val_ff    <= s3_val_ff;
         s4_pnum_ff   <= s3_pnum_ff;
         s4_qprod_ff  <= s3_qprod_ff;
         s4_tprod_ff  <= s3_tprod_ff;
         s4_prec_ff   <= s4_prec_in;
         s4_qrec_ff   <= s4_qrec_in;
         s4_trec_ff   <= s4_trec_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 5: the estimates can be one short, fix up from the remainder
   always_comb begin
      p_est = s4_prec_ff[P_SHIFT +: CHAN_W];
      q_est = s4_qrec_ff[Q_SHIFT +: CHAN_W];
      t_est = s4_trec_ff[Q_SHIFT +: CHAN_W];

      p_rem = (PNUM_W+1)'(s4_pnum_ff) - (PNUM_W+1)'(p_est) * (PNUM_W+1)'(CHAN_MAX);
      q_rem = s4_qprod_ff - QPROD_W'(q_est) * QPROD_W'(FRAC_DEN);
      t_rem = s4_tprod_ff - QPROD_W'(t_est) * QPROD_W'(FRAC_DEN);

      p_chan = (p_rem >= (PNUM_W+1)'(CHAN_MAX)) ? p_est + 1'b1 : p_est;
      q_chan = (q_rem >= QPROD_W'(FRAC_DEN)) ? q_est + 1'b1 : q_est;
      t_chan = (t_rem >= QPROD_W'(FRAC_DEN)) ? t_est + 1'b1 : t_est;

      case (s4_sector_ff)
         SECTOR_RED_YELLOW: begin
            rsp_red_in   = s4_val_ff;
            rsp_green_in = t_chan;
            rsp_blue_in  = p_chan;
         end
         SECTOR_YELLOW_GRN: begin
            rsp_red_in   = q_chan;
            rsp_green_in = s4_val_ff;
            rsp_blue_in  = p_chan;
         end
         SECTOR_GREEN_CYAN: begin
            rsp_red_in   = p_chan;
            rsp_green_in = s4_val_ff;
            rsp_blue_in  = t_chan;
         end
         SECTOR_CYAN_BLUE: begin
            rsp_red_in   = p_chan;
            rsp_green_in = q_chan;
            rsp_blue_in  = s4_val_ff;
         end
         SECTOR_BLUE_MAG: begin
            rsp_red_in   = t_chan;
            rsp_green_in = p_chan;
            rsp_blue_in  = s4_val_ff;
         end
         default: begin
            rsp_red_in   = s4_val_ff;
            rsp_green_in = p_chan;
            rsp_blue_in  = q_chan;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s5_ready) begin
         rsp_valid_ff <= s4_valid_ff;
      end
      if (s5_ready && s4_valid_ff) begin
         rsp_red_ff   <= rsp_red_in;
         rsp_green_ff <= rsp_green_in;
         rsp_blue_ff  <= rsp_blue_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_red_ff;
   assign rsp_green = rsp_green_ff;
   assign rsp_blue  = rsp_blue_ff;

endmodule

FILE: src/hsv2rgb_checker.sv
module hsv2rgb_checker
   import hsv2rgb_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAN_W-1:0] rsp_red,
   input logic [CHAN_W-1:0] rsp_green,
   input logic [CHAN_W-1:0] rsp_blue
);

   localparam int OCC_W = $clog2(PIPE_DEPTH + 1);

   // requests in flight, seen from the ports
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic             req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      occ_in = occ_ff;
      if (req_fire && !rsp_fire) begin
         occ_in = occ_ff + 1'b1;
      end else if (!req_fire && rsp_fire) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red)
         && $stable(rsp_green) && $stable(rsp_blue))
      else $error("stalled result dropped or changed");

   // no result without a request in flight
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> occ_ff != '0)
      else $error("result with no request outstanding");

   // never more in flight than the pipeline holds
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(PIPE_DEPTH))
      else $error("more requests in flight than pipeline stages");

   // back-pressure only comes from a stalled output
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused while output is free");

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_checker u_hsv2rgb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_red   (rsp_red),
   .rsp_green (rsp_green),
   .rsp_blue  (rsp_blue)
);

FILE: test/hsv_rgb_checker.sv
`timescale 1ns / 100ps

module hsv_rgb_checker
   import hsv2rgb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [HUE_W-1:0]  req_hue_deg,
   input  logic [CHAN_W-1:0] req_saturation,
   input  logic [CHAN_W-1:0] req_brightness,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [CHAN_W-1:0] rsp_red,
   input  logic [CHAN_W-1:0] rsp_green,
   input  logic [CHAN_W-1:0] rsp_blue,
   output int                mismatch_count,
   output int                pixels_in_flight
);

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [CHAN_W-1:0] sat;
      logic [CHAN_W-1:0] val;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_rgb_type;

   pixel_rgb_type expected_rgb_q[$];
   int            rgb_seen;

   initial begin
      mismatch_count   = 0;
      pixels_in_flight = 0;
      rgb_seen         = 0;
   end

   // six-sector conversion, exact integer quotients truncated toward zero
   function automatic pixel_rgb_type predict_rgb(logic [HUE_W-1:0] hue,
                                                 logic [CHAN_W-1:0] sat,
                                                 logic [CHAN_W-1:0] val);
      int            h;
      int            s;
      int            v;
      int            frac;
      int            floor_lvl;
      int            falling;
      int            rising;
      sector_type    sec;
      pixel_rgb_type px;
      h         = hue;
      s         = sat;
      v         = val;
      sec       = sector_type'((h / SECTOR_DEG) % SECTOR_CNT);
      frac      = h % SECTOR_DEG;
      floor_lvl = v * (CHAN_MAX - s) / CHAN_MAX;
      falling   = v * (FRAC_DEN - s * frac) / FRAC_DEN;
      rising    = v * (FRAC_DEN - s * (SECTOR_DEG - frac)) / FRAC_DEN;
      px.hue    = hue;
      px.sat    = sat;
      px.val    = val;
      case (sec)
         SECTOR_RED_YELLOW: begin
            px.red = v[CHAN_W-1:0];         px.green = rising[CHAN_W-1:0];
            px.blue = floor_lvl[CHAN_W-1:0];
         end
         SECTOR_YELLOW_GRN: begin
            px.red = falling[CHAN_W-1:0];   px.green = v[CHAN_W-1:0];
            px.blue = floor_lvl[CHAN_W-1:0];
         end
         SECTOR_GREEN_CYAN: begin
            px.red = floor_lvl[CHAN_W-1:0]; px.green = v[CHAN_W-1:0];
            px.blue = rising[CHAN_W-1:0];
         end
         SECTOR_CYAN_BLUE: begin
            px.red = floor_lvl[CHAN_W-1:0]; px.green = falling[CHAN_W-1:0];
            px.blue = v[CHAN_W-1:0];
         end
         SECTOR_BLUE_MAG: begin
            px.red = rising[CHAN_W-1:0];    px.green = floor_lvl[CHAN_W-1:0];
            px.blue = v[CHAN_W-1:0];
         end
         default: begin
            px.red = v[CHAN_W-1:0];         px.green = floor_lvl[CHAN_W-1:0];
            px.blue = falling[CHAN_W-1:0];
         end
      endcase
      return px;
   endfunction

   task automatic report_mismatch(string what);
      $display("[%0t] rgb check: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic check_channel(string chan, logic [CHAN_W-1:0] got,
                                logic [CHAN_W-1:0] want, pixel_rgb_type px);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d (h=%0d s=%0d v=%0d) %s got %0d want %0d",
                                   rgb_seen, px.hue, px.sat, px.val, chan, got, want));
      end
   endtask

   always @(posedge clock) begin
      pixel_rgb_type px;
      if (reset) begin
         expected_rgb_q.delete();
         pixels_in_flight <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rgb_q.push_back(predict_rgb(req_hue_deg, req_saturation,
                                                 req_brightness));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rgb_q.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with no request pending",
                                         rgb_seen));
            end else begin
               px = expected_rgb_q.pop_front();
               check_channel("red",   rsp_red,   px.red,   px);
               check_channel("green", rsp_green, px.green, px);
               check_channel("blue",  rsp_blue,  px.blue,  px);
            end
            rgb_seen++;
         end
         pixels_in_flight <= expected_rgb_q.size();
      end
   end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import hsv2rgb_pkg::*;

   localparam int RANDOM_PIXELS  = 950;
   localparam int MODE_SPAN      = 80;    // requests per idle-mode setting
   localparam int MAX_IDLE       = 6;
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
   localparam int DIRECTED_CNT   = 24;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [HUE_W-1:0]  req_hue_deg;
   logic [CHAN_W-1:0] req_saturation;
   logic [CHAN_W-1:0] req_brightness;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [CHAN_W-1:0] rsp_red;
   logic [CHAN_W-1:0] rsp_green;
   logic [CHAN_W-1:0] rsp_blue;

   int mismatch_count;
   int pixels_in_flight;
   int quiet_cycles;

   // idle modes, changed between stretches of the random part
   bit send_idle_en;
   bit recv_idle_en;

   // directed pixels: hue, saturation, brightness
   // black, white, each sector edge on both sides, hues past 359 that wrap,
   // the largest 9-bit hue, zero brightness with saturation, gray levels
   int directed_px [DIRECTED_CNT][3] = '{
      '{  0,   0,   0}, '{  0, 255, 255}, '{  0,   0, 255}, '{359, 255, 255},
      '{360, 255, 255}, '{511, 255, 255}, '{511,   0,   0}, '{ 59, 255, 255},
      '{ 60, 255, 255}, '{119, 255, 200}, '{120, 255, 255}, '{179, 128, 255},
      '{180, 255, 255}, '{239, 255,  77}, '{240, 255, 255}, '{299, 200, 255},
      '{300, 255, 255}, '{419, 255, 255}, '{420, 128, 255}, '{480, 255, 255},
      '{ 30, 128,   0}, '{  1,   1,   1}, '{256, 170,  85}, '{255,  85, 170}
   };

   hsv_to_rgb_converter_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_hue_deg    (req_hue_deg),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   hsv_rgb_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_hue_deg      (req_hue_deg),
      .req_saturation   (req_saturation),
      .req_brightness   (req_brightness),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .mismatch_count   (mismatch_count),
      .pixels_in_flight (pixels_in_flight)
   );

   // 50 MHz clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // known values on every input from time zero
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_hue_deg    = '0;
      req_saturation = '0;
      req_brightness = '0;
      rsp_ready      = 1'b0;
      send_idle_en   = 1'b1;
      recv_idle_en   = 1'b1;
   end

   // one request on the input channel; called at a falling edge, returns at
   // the falling edge after the request is taken, with valid still high so
   // back-to-back requests never drop it
   task automatic send_pixel(int hue, int sat, int val);
      int gap;
      gap = send_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_hue_deg    <= hue[HUE_W-1:0];
      req_saturation <= sat[CHAN_W-1:0];
      req_brightness <= val[CHAN_W-1:0];
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // channel level biased toward the ends of the range
   function automatic int pick_level();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return 255;
         2:       return $urandom_range(0, 3);
         3:       return $urandom_range(252, 255);
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   // hue mostly on the circle, some on sector edges, some past 359
   function automatic int pick_hue();
      int h;
      case ($urandom_range(0, 9))
         0: h = $urandom_range(360, (1 << HUE_W) - 1);
         1, 2: begin
            h = $urandom_range(0, 8) * SECTOR_DEG + ($urandom_range(0, 1) ? 0 : 59);
            if (h > (1 << HUE_W) - 1) h = (1 << HUE_W) - 1;
         end
         default: h = $urandom_range(0, 359);
      endcase
      return h;
   endfunction

   // receiver: random stall before each result, sometimes none at all
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = recv_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // watchdog: ends the run if neither channel moves for too long;
   // cleared while reset is high
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake in %0d cycles", WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus and verdict
   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed corners with idling on both sides
      for (int i = 0; i < DIRECTED_CNT; i++) begin
         send_pixel(directed_px[i][0], directed_px[i][1], directed_px[i][2]);
      end

      // random pixels; idle modes rotate so there are full-rate stretches,
      // sender-only and receiver-only gaps, and both together
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         if (i % MODE_SPAN == 0) begin
            send_idle_en = $urandom_range(0, 1);
            recv_idle_en = $urandom_range(0, 1);
         end
         send_pixel(pick_hue(), pick_level(), pick_level());
      end
      req_valid <= 1'b0;
      recv_idle_en = 1'b1;

      // drain, then keep watching for anything unexpected before the verdict
      while (pixels_in_flight != 0) @(posedge clock);
      repeat (4 * PIPE_DEPTH) @(posedge clock);

      if (mismatch_count == 0 && pixels_in_flight == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
